/* rtl/core/msrf_pkg.sv */
// ---------------------------------------------------------------------------
// msrf_pkg: shared types and constants for the message slot ring FIFO
// Field widths, status codes, controller states and the command/status
// structs that join the controller to the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package msrf_pkg;

    // Default geometry of the ring
    localparam int SLOT_COUNT_DEF = 16;
    localparam int SLOT_BYTES_DEF = 64;
    // Bytes of each slot reserved for the stored length
    localparam int SLOT_HDR_BYTES = 4;

    // Fixed field widths
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 6;
    localparam int STATUS_W = 2;
    localparam int DATA_W   = 16;
    localparam int USER_W   = 2;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_BYTE   = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_COMMIT = 2'd2,
        ST_REJECT = 2'd3
    } status_t;

    // Input kind carried in tuser bit 0
    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    // Controller states
    typedef enum logic [1:0] {
        CTRL_IDLE     = 2'd0,
        CTRL_POP_LEN  = 2'd1,
        CTRL_POP_BYTE = 2'd2
    } ctrl_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic take;       // input word accepted this cycle
        logic pop_setup;  // latch pop length, advance head
        logic pop_emit;   // load next popped byte into the output register
    } msrf_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic is_pop;     // offered word is a pop
        logic ring_empty; // no committed message
        logic n_zero;     // pop delivers no bytes
        logic emit_final; // byte being emitted is the last of the pop
        logic out_free;   // output register can take a new word
    } msrf_sts_t;

endpackage

`default_nettype wire

/* rtl/core/msrf_ctrl.sv */
// ---------------------------------------------------------------------------
// msrf_ctrl: controller of the message slot ring FIFO
// Accepts input words while idle and sequences the length lookup and the
// byte stream of a pop.
// ---------------------------------------------------------------------------
`default_nettype none

module msrf_ctrl
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 s_tvalid,
    output logic                s_tready,
    input  msrf_pkg::msrf_sts_t sts,
    output msrf_pkg::msrf_cmd_t cmd
);

    msrf_pkg::ctrl_state_t state_reg;
    msrf_pkg::ctrl_state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= msrf_pkg::CTRL_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        s_tready      = 1'b0;
        cmd.take      = 1'b0;
        cmd.pop_setup = 1'b0;
        cmd.pop_emit  = 1'b0;
        case (state_reg)
            msrf_pkg::CTRL_IDLE:
            begin
                s_tready = sts.out_free;
                cmd.take = s_tvalid && sts.out_free;
                if (cmd.take && sts.is_pop && !sts.ring_empty)
                begin
                    state_next = msrf_pkg::CTRL_POP_LEN;
                end
            end
            msrf_pkg::CTRL_POP_LEN:
            begin
                // output register is always free here
                cmd.pop_setup = 1'b1;
                state_next    = sts.n_zero ? msrf_pkg::CTRL_IDLE : msrf_pkg::CTRL_POP_BYTE;
            end
            msrf_pkg::CTRL_POP_BYTE:
            begin
                cmd.pop_emit = sts.out_free;
                if (sts.out_free && sts.emit_final)
                begin
                    state_next = msrf_pkg::CTRL_IDLE;
                end
            end
            default:
            begin
                state_next = msrf_pkg::CTRL_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/msrf_datapath.sv */
// ---------------------------------------------------------------------------
// msrf_datapath: storage and pointers of the message slot ring FIFO
// Slot byte memory, length memory, head/tail pointers, push bookkeeping
// and the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module msrf_datapath
#(
    parameter int SLOT_COUNT = msrf_pkg::SLOT_COUNT_DEF,
    parameter int SLOT_BYTES = msrf_pkg::SLOT_BYTES_DEF
)
(
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire  [msrf_pkg::DATA_W-1:0]  s_tdata,
    input  wire  [msrf_pkg::USER_W-1:0]  s_tuser,
    input  wire                          s_tlast,
    output logic                         m_tvalid,
    input  wire                          m_tready,
    output logic [msrf_pkg::DATA_W-1:0]  m_tdata,
    output logic [msrf_pkg::USER_W-1:0]  m_tuser,
    output logic                         m_tlast,
    input  msrf_pkg::msrf_cmd_t          cmd,
    output msrf_pkg::msrf_sts_t          sts
);

    localparam int PAYLOAD   = SLOT_BYTES - msrf_pkg::SLOT_HDR_BYTES;
    localparam int MEM_DEPTH = SLOT_COUNT * PAYLOAD;
    localparam int SLOT_W    = $clog2(SLOT_COUNT);
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int WC_W      = $clog2(PAYLOAD + 1);
    localparam int CMP_W     = (WC_W > msrf_pkg::LEN_W) ? WC_W : msrf_pkg::LEN_W;
    localparam int LEN_W     = msrf_pkg::LEN_W;
    localparam int BYTE_W    = msrf_pkg::BYTE_W;

    localparam logic [SLOT_W-1:0] SLOT_LAST    = SLOT_W'(SLOT_COUNT - 1);
    localparam logic [ADDR_W-1:0] PAYLOAD_STEP = ADDR_W'(PAYLOAD);
    localparam logic [WC_W-1:0]   PAYLOAD_MAX  = WC_W'(PAYLOAD);

    // Input fields
    logic                action;
    logic [BYTE_W-1:0]   in_byte;
    logic                has_byte;
    logic                in_last;
    logic [LEN_W-1:0]    pop_limit;

    assign action    = s_tuser[0];
    assign has_byte  = s_tuser[1];
    assign in_byte   = s_tdata[BYTE_W-1:0];
    assign pop_limit = s_tdata[BYTE_W +: LEN_W];
    assign in_last   = s_tlast;

    // Memories
    logic [BYTE_W-1:0] byte_mem [MEM_DEPTH];
    logic [WC_W-1:0]   len_mem  [SLOT_COUNT];

    // Ring and push state
    logic [SLOT_W-1:0] head_reg,      head_next;
    logic [SLOT_W-1:0] tail_reg,      tail_next;
    logic [ADDR_W-1:0] head_base_reg, head_base_next;
    logic [ADDR_W-1:0] tail_base_reg, tail_base_next;
    logic [WC_W-1:0]   wc_reg,        wc_next;
    logic              open_reg,      open_next;
    logic              reject_reg,    reject_next;

    // Pop working registers
    logic [ADDR_W-1:0] pop_base_reg;
    logic [LEN_W-1:0]  limit_reg;
    logic [LEN_W-1:0]  n_reg;
    logic [LEN_W-1:0]  idx_reg, idx_next;
    logic [WC_W-1:0]   len_rd_reg;
    logic [BYTE_W-1:0] byte_rd_reg;

    // Output register
    logic                  out_valid_reg, out_valid_next;
    msrf_pkg::status_t     out_status_reg, out_status_next;
    logic [BYTE_W-1:0]     out_byte_reg,   out_byte_next;
    logic                  out_last_reg,   out_last_next;
    logic [LEN_W-1:0]      out_len_reg,    out_len_next;

    logic [SLOT_W-1:0] head_inc, tail_inc;
    logic              ring_full, ring_empty, out_free;
    logic              rej_eff, do_push, do_pop, byte_wr, commit;
    logic [WC_W-1:0]   wc_eff, wc_after;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [CMP_W-1:0]  lim_wide, stored_wide, n_wide, wc_wide;
    logic [LEN_W-1:0]  n_calc, idx_inc;
    logic              emit_final;

    assign head_inc   = (head_reg == SLOT_LAST) ? '0 : head_reg + 1'b1;
    assign tail_inc   = (tail_reg == SLOT_LAST) ? '0 : tail_reg + 1'b1;
    assign ring_full  = (tail_inc == head_reg);
    assign ring_empty = (head_reg == tail_reg);
    assign out_free   = !out_valid_reg || m_tready;

    // Push: fullness is judged at the first word of a message
    assign do_push  = cmd.take && (action == msrf_pkg::ACT_PUSH);
    assign do_pop   = cmd.take && (action == msrf_pkg::ACT_POP);
    assign rej_eff  = open_reg ? reject_reg : ring_full;
    assign wc_eff   = open_reg ? wc_reg : '0;
    assign byte_wr  = do_push && has_byte && !rej_eff && (wc_eff < PAYLOAD_MAX);
    assign wc_after = wc_eff + {{(WC_W-1){1'b0}}, byte_wr};
    assign wr_addr  = tail_base_reg + ADDR_W'(wc_eff);
    assign commit   = do_push && in_last && !rej_eff;
    assign wc_wide  = CMP_W'(wc_after);

    // Pop length: the smaller of limit and stored length
    assign lim_wide    = CMP_W'(limit_reg);
    assign stored_wide = CMP_W'(len_rd_reg);
    assign n_wide      = (lim_wide < stored_wide) ? lim_wide : stored_wide;
    assign n_calc      = n_wide[LEN_W-1:0];
    assign idx_inc     = idx_reg + 1'b1;
    assign emit_final  = (idx_inc == n_reg);

    // Byte read address follows the next index, so read data matches idx_reg
    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.pop_setup)
        begin
            idx_next = '0;
        end
        else if (cmd.pop_emit)
        begin
            idx_next = idx_inc;
        end
    end
    assign rd_addr = pop_base_reg + ADDR_W'(idx_next);

    // Write the memories and register their reads
    always_ff @(posedge clk)
    begin
        if (byte_wr)
        begin
            byte_mem[wr_addr] <= in_byte;
        end
        if (commit)
        begin
            len_mem[tail_reg] <= wc_after;
        end
        byte_rd_reg <= byte_mem[rd_addr];
        len_rd_reg  <= len_mem[head_reg];
    end

    // Next ring and push state
    always_comb
    begin
        head_next      = head_reg;
        head_base_next = head_base_reg;
        tail_next      = tail_reg;
        tail_base_next = tail_base_reg;
        wc_next        = wc_reg;
        open_next      = open_reg;
        reject_next    = reject_reg;
        if (do_push)
        begin
            if (in_last)
            begin
                open_next   = 1'b0;
                reject_next = 1'b0;
                wc_next     = '0;
                if (!rej_eff)
                begin
                    tail_next      = tail_inc;
                    tail_base_next = (tail_reg == SLOT_LAST) ? '0
                                                             : tail_base_reg + PAYLOAD_STEP;
                end
            end
            else
            begin
                open_next   = 1'b1;
                reject_next = rej_eff;
                wc_next     = wc_after;
            end
        end
        if (cmd.pop_setup)
        begin
            head_next      = head_inc;
            head_base_next = (head_reg == SLOT_LAST) ? '0 : head_base_reg + PAYLOAD_STEP;
        end
    end

    // Next output word
    always_comb
    begin
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        out_len_next    = out_len_reg;
        if (do_push && in_last)
        begin
            out_valid_next  = 1'b1;
            out_status_next = rej_eff ? msrf_pkg::ST_REJECT : msrf_pkg::ST_COMMIT;
            out_byte_next   = '0;
            out_last_next   = 1'b1;
            out_len_next    = rej_eff ? '0 : wc_wide[LEN_W-1:0];
        end
        else if (do_pop && ring_empty)
        begin
            out_valid_next  = 1'b1;
            out_status_next = msrf_pkg::ST_EMPTY;
            out_byte_next   = '0;
            out_last_next   = 1'b1;
            out_len_next    = '0;
        end
        else if (cmd.pop_setup && (n_calc == '0))
        begin
            out_valid_next  = 1'b1;
            out_status_next = msrf_pkg::ST_BYTE;
            out_byte_next   = '0;
            out_last_next   = 1'b1;
            out_len_next    = '0;
        end
        else if (cmd.pop_emit)
        begin
            out_valid_next  = 1'b1;
            out_status_next = msrf_pkg::ST_BYTE;
            out_byte_next   = byte_rd_reg;
            out_last_next   = emit_final;
            out_len_next    = n_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            head_base_reg <= '0;
            tail_base_reg <= '0;
            wc_reg        <= '0;
            open_reg      <= 1'b0;
            reject_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            head_base_reg <= head_base_next;
            tail_base_reg <= tail_base_next;
            wc_reg        <= wc_next;
            open_reg      <= open_next;
            reject_reg    <= reject_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (do_pop)
        begin
            pop_base_reg <= head_base_reg;
            limit_reg    <= pop_limit;
        end
        if (cmd.pop_setup)
        begin
            n_reg <= n_calc;
        end
        idx_reg        <= idx_next;
        out_status_reg <= out_status_next;
        out_byte_reg   <= out_byte_next;
        out_last_reg   <= out_last_next;
        out_len_reg    <= out_len_next;
    end

    // Status to controller
    assign sts.is_pop     = (action == msrf_pkg::ACT_POP);
    assign sts.ring_empty = ring_empty;
    assign sts.n_zero     = (n_calc == '0);
    assign sts.emit_final = emit_final;
    assign sts.out_free   = out_free;

    // Output ports
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(msrf_pkg::DATA_W - BYTE_W - LEN_W){1'b0}}, out_len_reg, out_byte_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

/* rtl/core/message_slot_ring_fifo.sv */
// ---------------------------------------------------------------------------
// message_slot_ring_fifo: ring of fixed-size message slots
// Pushes store byte messages into slots, pops stream the oldest message
// back out, truncated to the reader's limit.
// ---------------------------------------------------------------------------
//
//  Channel  Dir  Handshake          Contents
//  s_*      in   s_tvalid/s_tready  tuser: action, has_byte; tdata: in_byte,
//                                   pop_limit; tlast: in_last
//  m_*      out  m_tvalid/m_tready  tuser: status; tdata: out_byte,
//                                   out_length; tlast: out_last
//
//  A push word is taken while idle. A pop is accepted, then looks up the
//  length in the length memory, then streams its bytes from the registered
//  read port of the byte memory; an empty ring answers when the pop is taken.
//  Reset clears pointers and push state; memories need no clearing pass.
//  A stalled output holds the controller and closes s_tready.
// ---------------------------------------------------------------------------
`default_nettype none

module message_slot_ring_fifo
#(
    parameter int SLOT_COUNT = msrf_pkg::SLOT_COUNT_DEF,
    parameter int SLOT_BYTES = msrf_pkg::SLOT_BYTES_DEF
)
(
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          s_tvalid,
    output logic                         s_tready,
    input  wire  [msrf_pkg::DATA_W-1:0]  s_tdata,   // [7:0] in_byte, [13:8] pop_limit
    input  wire  [msrf_pkg::USER_W-1:0]  s_tuser,   // [0] action, [1] has_byte
    input  wire                          s_tlast,
    output logic                         m_tvalid,
    input  wire                          m_tready,
    output logic [msrf_pkg::DATA_W-1:0]  m_tdata,   // [7:0] out_byte, [13:8] out_length
    output logic [msrf_pkg::USER_W-1:0]  m_tuser,   // [1:0] status
    output logic                         m_tlast
);

    msrf_pkg::msrf_cmd_t cmd;
    msrf_pkg::msrf_sts_t sts;

    // Sequence accepts and pops
    msrf_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Store messages and drive results
    msrf_datapath
    #(
        .SLOT_COUNT (SLOT_COUNT),
        .SLOT_BYTES (SLOT_BYTES)
    )
    u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule

`default_nettype wire
